### src/rve_pkg.sv
// Shared types and constants for the RV32I execute unit.
// No dependencies; the files that use this package refer to it by scoped names.
`default_nettype none
package rve_pkg;

    localparam int MEM_BYTES_DEF = 16384;
    localparam logic [4:0] REG_A0 = 5'd10;
    localparam logic [4:0] REG_A7 = 5'd17;

    typedef enum logic [5:0] {
        CMD_LUI, CMD_AUIPC, CMD_JAL, CMD_JALR,
        CMD_BEQ, CMD_BNE, CMD_BLT, CMD_BGE, CMD_BLTU, CMD_BGEU,
        CMD_LB, CMD_LH, CMD_LW, CMD_LBU, CMD_LHU, CMD_SB, CMD_SH, CMD_SW,
        CMD_ADDI, CMD_SLTI, CMD_SLTIU, CMD_XORI, CMD_ORI, CMD_ANDI, CMD_SLLI, CMD_SRLI,
        CMD_ADD, CMD_SUB, CMD_SLL, CMD_SRL, CMD_SRA, CMD_SLT, CMD_SLTU,
        CMD_XOR, CMD_OR, CMD_AND, CMD_ECALL, CMD_EBREAK
    } t_cmd;

    typedef enum logic [1:0] {
        SZ_B, SZ_H, SZ_W
    } t_size;

    typedef struct packed {
        logic        wr;
        logic        rd;
        t_size       size;
        logic [31:0] addr;
        logic [31:0] data;
    } t_mem_req;

    typedef struct packed {
        logic [31:0] npc;
        logic        wr;
        logic [31:0] val;
        logic        ecall;
        logic        halt;
        logic        ld_sext;
        t_mem_req    mem;
    } t_ex_res;

endpackage
`default_nettype wire

### src/rv32i_execute_unit.sv
// Top level of the RV32I execute unit: register file, pc, data memory, pipeline.
// Depends on rve_pkg, rve_ram, rve_alu and rve_dmem.
// An instruction enters the execute stage the cycle after it is accepted, with
// both register operands read from the register-file RAMs (a same-cycle write is
// forwarded). Non-memory-read instructions can be accepted one per cycle while the
// output is not stalled; a load also passes through a wait stage for the data
// memory read, and the next instruction is accepted only as it leaves. After reset
// the data memory is cleared one 4-byte row per cycle, all MEM_BYTES/4 rows, during
// which no instruction is accepted; configuration writes are taken as always.
// MEM_BYTES must be a power of two. Writing start_address also reloads the pc.
`default_nettype none
module rv32i_execute_unit #(
    parameter int MEM_BYTES = rve_pkg::MEM_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [5:0]  i_cmd,
    input  wire logic [4:0]  i_dest_reg,
    input  wire logic [4:0]  i_src1_reg,
    input  wire logic [4:0]  i_src2_reg,
    input  wire logic [31:0] i_immediate,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_next_pc,
    output logic             o_reg_written,
    output logic [4:0]       o_write_index,
    output logic [31:0]      o_write_value,
    output logic             o_halted,
    output logic             o_env_call,
    output logic [31:0]      o_call_number,
    output logic [31:0]      o_call_argument
);
    logic [31:0] r_start, r_pc;
    logic        r_halt;
    logic        cfg_wr, accept, busy, out_free, x_go, x_is_load, m_go;
    logic [4:0]  ra1, ra2;
    logic [31:0] q1, q2, op_a, op_b;
    logic [31:0] r_rf_vld;
    logic        r_byp_en;
    logic [4:0]  r_byp_idx;
    logic [31:0] r_byp_val;
    logic        wb_en;
    logic [4:0]  wb_idx;
    logic [31:0] wb_val;

    logic        r_x_valid;
    logic [5:0]  r_x_cmd;
    logic [4:0]  r_x_rd, r_x_ra1, r_x_ra2;
    logic [31:0] r_x_imm;
    rve_pkg::t_ex_res  res;
    rve_pkg::t_mem_req mreq;
    logic [31:0] mrdata, ld_val;

    logic         r_m_valid, r_m_sext;
    logic [4:0]   r_m_rd;
    rve_pkg::t_size r_m_size;
    logic [31:0]  r_m_npc;

    logic        r_o_valid, r_o_wr, r_o_halted, r_o_ecall;
    logic [4:0]  r_o_idx;
    logic [31:0] r_o_npc, r_o_val, r_o_cnum, r_o_carg;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? r_start : '0;

    // handshake; a load leaving the wait stage frees the input on the same edge
    assign out_free   = !r_o_valid || i_out_ready;
    assign x_is_load  = res.mem.rd && !r_halt;
    assign x_go       = r_x_valid && (x_is_load || out_free);
    assign m_go       = r_m_valid && out_free;
    assign o_in_ready = !busy && (r_m_valid ? m_go : (!r_x_valid || (x_go && !x_is_load)));
    assign accept     = i_in_valid && o_in_ready;

    // ecall reads a7 and a0 through the two operand ports
    assign ra1 = (rve_pkg::t_cmd'(i_cmd) == rve_pkg::CMD_ECALL) ? rve_pkg::REG_A7 : i_src1_reg;
    assign ra2 = (rve_pkg::t_cmd'(i_cmd) == rve_pkg::CMD_ECALL) ? rve_pkg::REG_A0 : i_src2_reg;

    always_comb begin
        wb_en  = 1'b0;
        wb_idx = r_x_rd;
        wb_val = res.val;
        if (m_go) begin
            wb_en  = (r_m_rd != 5'd0);
            wb_idx = r_m_rd;
            wb_val = ld_val;
        end else if (x_go && !x_is_load && !r_halt) begin
            wb_en = res.wr && (r_x_rd != 5'd0);
        end
    end

    rve_ram #(.WIDTH(32), .DEPTH(32)) u_rf1 (
        .i_clk(i_clk), .i_we(wb_en), .i_waddr(wb_idx), .i_wdata(wb_val),
        .i_re(accept), .i_raddr(ra1), .o_rdata(q1)
    );
    rve_ram #(.WIDTH(32), .DEPTH(32)) u_rf2 (
        .i_clk(i_clk), .i_we(wb_en), .i_waddr(wb_idx), .i_wdata(wb_val),
        .i_re(accept), .i_raddr(ra2), .o_rdata(q2)
    );

    // forward the write that landed on the read edge; unwritten entries read zero
    always_comb begin
        op_a = r_rf_vld[r_x_ra1] ? q1 : '0;
        op_b = r_rf_vld[r_x_ra2] ? q2 : '0;
        if (r_byp_en && r_byp_idx == r_x_ra1) begin
            op_a = r_byp_val;
        end
        if (r_byp_en && r_byp_idx == r_x_ra2) begin
            op_b = r_byp_val;
        end
    end

    rve_alu u_alu (
        .i_cmd(r_x_cmd), .i_pc(r_pc), .i_a(op_a), .i_b(op_b), .i_imm(r_x_imm),
        .o_res(res)
    );

    always_comb begin
        mreq    = res.mem;
        mreq.wr = res.mem.wr && x_go && !r_halt;
        mreq.rd = x_is_load && x_go;
    end

    rve_dmem #(.MEM_BYTES(MEM_BYTES)) u_dmem (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(mreq), .o_busy(busy), .o_rdata(mrdata)
    );

    always_comb begin
        case (r_m_size)
            rve_pkg::SZ_B: ld_val = {{24{mrdata[7] & r_m_sext}}, mrdata[7:0]};
            rve_pkg::SZ_H: ld_val = {{16{mrdata[15] & r_m_sext}}, mrdata[15:0]};
            default:       ld_val = mrdata;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start   <= '0;
            r_pc      <= '0;
            r_halt    <= 1'b0;
            r_rf_vld  <= '0;
            r_byp_en  <= 1'b0;
            r_x_valid <= 1'b0;
            r_m_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (wb_en) begin
                r_rf_vld[wb_idx] <= 1'b1;
            end
            if (accept) begin
                r_byp_en <= wb_en;
            end
            if (accept) begin
                r_x_valid <= 1'b1;
            end else if (x_go) begin
                r_x_valid <= 1'b0;
            end
            if (x_go && x_is_load) begin
                r_m_valid <= 1'b1;
            end else if (m_go) begin
                r_m_valid <= 1'b0;
            end
            if ((x_go && !x_is_load) || m_go) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
            if (x_go && !r_halt && res.halt) begin
                r_halt <= 1'b1;
            end
            if (cfg_wr) begin
                r_start <= pwdata;
                r_pc    <= pwdata;
            end else if (x_go && !r_halt) begin
                r_pc <= res.npc;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x_cmd   <= i_cmd;
            r_x_rd    <= i_dest_reg;
            r_x_ra1   <= ra1;
            r_x_ra2   <= ra2;
            r_x_imm   <= i_immediate;
            r_byp_idx <= wb_idx;
            r_byp_val <= wb_val;
        end
        if (x_go && x_is_load) begin
            r_m_rd   <= r_x_rd;
            r_m_size <= res.mem.size;
            r_m_sext <= res.ld_sext;
            r_m_npc  <= res.npc;
        end
        if (m_go) begin
            r_o_npc    <= r_m_npc;
            r_o_wr     <= (r_m_rd != 5'd0);
            r_o_idx    <= r_m_rd;
            r_o_val    <= (r_m_rd != 5'd0) ? ld_val : '0;
            r_o_halted <= 1'b0;
            r_o_ecall  <= 1'b0;
            r_o_cnum   <= '0;
            r_o_carg   <= '0;
        end else if (x_go && !x_is_load) begin
            if (r_halt) begin
                r_o_npc    <= r_pc;
                r_o_wr     <= 1'b0;
                r_o_idx    <= '0;
                r_o_val    <= '0;
                r_o_halted <= 1'b1;
                r_o_ecall  <= 1'b0;
                r_o_cnum   <= '0;
                r_o_carg   <= '0;
            end else begin
                r_o_npc    <= res.npc;
                r_o_wr     <= wb_en;
                r_o_idx    <= wb_en ? r_x_rd : '0;
                r_o_val    <= wb_en ? res.val : '0;
                r_o_halted <= res.halt;
                r_o_ecall  <= res.ecall;
                r_o_cnum   <= res.ecall ? op_a : '0;
                r_o_carg   <= res.ecall ? op_b : '0;
            end
        end
    end

    assign o_out_valid     = r_o_valid;
    assign o_next_pc       = r_o_npc;
    assign o_reg_written   = r_o_wr;
    assign o_write_index   = r_o_idx;
    assign o_write_value   = r_o_val;
    assign o_halted        = r_o_halted;
    assign o_env_call      = r_o_ecall;
    assign o_call_number   = r_o_cnum;
    assign o_call_argument = r_o_carg;

    a_m_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid |-> !r_x_valid)
        else $error("load wait stage overlaps execute stage");
    a_no_x0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wb_en |-> (wb_idx != 5'd0))
        else $error("write to x0");
    a_clr_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (!accept && !r_x_valid))
        else $error("instruction taken during memory clear");
    a_halt_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_halt && x_go) |=> !wb_en || r_m_valid)
        else $error("register write after halt");
endmodule
`default_nettype wire

### src/rve_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module rve_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;
endmodule
`default_nettype wire

### src/rve_alu.sv
// Execute logic: next pc, register result, branch decision and memory request.
// Depends on rve_pkg.
`default_nettype none
module rve_alu (
    input  wire logic [5:0]   i_cmd,
    input  wire logic [31:0]  i_pc,
    input  wire logic [31:0]  i_a,
    input  wire logic [31:0]  i_b,
    input  wire logic [31:0]  i_imm,
    output rve_pkg::t_ex_res  o_res
);
    logic [31:0] pc4;
    logic [31:0] sum;
    logic        taken;

    always_comb begin
        pc4   = i_pc + 32'd4;
        sum   = i_a + i_imm;
        taken = 1'b0;
        o_res = '0;
        o_res.npc      = pc4;
        o_res.mem.addr = sum;
        o_res.mem.data = i_b;
        o_res.mem.size = rve_pkg::SZ_W;
        case (rve_pkg::t_cmd'(i_cmd))
            rve_pkg::CMD_LUI:   begin o_res.val = i_imm; o_res.wr = 1'b1; end
            rve_pkg::CMD_AUIPC: begin o_res.val = i_pc + i_imm; o_res.wr = 1'b1; end
            rve_pkg::CMD_JAL: begin
                o_res.val = pc4; o_res.wr = 1'b1; o_res.npc = i_pc + i_imm;
            end
            rve_pkg::CMD_JALR: begin
                o_res.val = pc4; o_res.wr = 1'b1; o_res.npc = {sum[31:1], 1'b0};
            end
            rve_pkg::CMD_BEQ:  taken = (i_a == i_b);
            rve_pkg::CMD_BNE:  taken = (i_a != i_b);
            rve_pkg::CMD_BLT:  taken = ($signed(i_a) < $signed(i_b));
            rve_pkg::CMD_BGE:  taken = !($signed(i_a) < $signed(i_b));
            rve_pkg::CMD_BLTU: taken = (i_a < i_b);
            rve_pkg::CMD_BGEU: taken = (i_a >= i_b);
            rve_pkg::CMD_LB: begin
                o_res.mem.rd = 1'b1; o_res.mem.size = rve_pkg::SZ_B;
                o_res.ld_sext = 1'b1; o_res.wr = 1'b1;
            end
            rve_pkg::CMD_LH: begin
                o_res.mem.rd = 1'b1; o_res.mem.size = rve_pkg::SZ_H;
                o_res.ld_sext = 1'b1; o_res.wr = 1'b1;
            end
            rve_pkg::CMD_LW: begin
                o_res.mem.rd = 1'b1; o_res.wr = 1'b1;
            end
            rve_pkg::CMD_LBU: begin
                o_res.mem.rd = 1'b1; o_res.mem.size = rve_pkg::SZ_B; o_res.wr = 1'b1;
            end
            rve_pkg::CMD_LHU: begin
                o_res.mem.rd = 1'b1; o_res.mem.size = rve_pkg::SZ_H; o_res.wr = 1'b1;
            end
            rve_pkg::CMD_SB: begin o_res.mem.wr = 1'b1; o_res.mem.size = rve_pkg::SZ_B; end
            rve_pkg::CMD_SH: begin o_res.mem.wr = 1'b1; o_res.mem.size = rve_pkg::SZ_H; end
            rve_pkg::CMD_SW: o_res.mem.wr = 1'b1;
            rve_pkg::CMD_ADDI:  begin o_res.val = sum; o_res.wr = 1'b1; end
            rve_pkg::CMD_SLTI: begin
                o_res.val = {31'd0, $signed(i_a) < $signed(i_imm)}; o_res.wr = 1'b1;
            end
            rve_pkg::CMD_SLTIU: begin o_res.val = {31'd0, i_a < i_imm}; o_res.wr = 1'b1; end
            rve_pkg::CMD_XORI:  begin o_res.val = i_a ^ i_imm; o_res.wr = 1'b1; end
            rve_pkg::CMD_ORI:   begin o_res.val = i_a | i_imm; o_res.wr = 1'b1; end
            rve_pkg::CMD_ANDI:  begin o_res.val = i_a & i_imm; o_res.wr = 1'b1; end
            rve_pkg::CMD_SLLI:  begin o_res.val = i_a << i_imm[4:0]; o_res.wr = 1'b1; end
            rve_pkg::CMD_SRLI:  begin o_res.val = i_a >> i_imm[4:0]; o_res.wr = 1'b1; end
            rve_pkg::CMD_ADD:   begin o_res.val = i_a + i_b; o_res.wr = 1'b1; end
            rve_pkg::CMD_SUB:   begin o_res.val = i_a - i_b; o_res.wr = 1'b1; end
            rve_pkg::CMD_SLL:   begin o_res.val = i_a << i_b[4:0]; o_res.wr = 1'b1; end
            rve_pkg::CMD_SRL:   begin o_res.val = i_a >> i_b[4:0]; o_res.wr = 1'b1; end
            rve_pkg::CMD_SRA: begin
                o_res.val = 32'($signed(i_a) >>> i_b[4:0]); o_res.wr = 1'b1;
            end
            rve_pkg::CMD_SLT: begin
                o_res.val = {31'd0, $signed(i_a) < $signed(i_b)}; o_res.wr = 1'b1;
            end
            rve_pkg::CMD_SLTU:  begin o_res.val = {31'd0, i_a < i_b}; o_res.wr = 1'b1; end
            rve_pkg::CMD_XOR:   begin o_res.val = i_a ^ i_b; o_res.wr = 1'b1; end
            rve_pkg::CMD_OR:    begin o_res.val = i_a | i_b; o_res.wr = 1'b1; end
            rve_pkg::CMD_AND:   begin o_res.val = i_a & i_b; o_res.wr = 1'b1; end
            rve_pkg::CMD_ECALL:  o_res.ecall = 1'b1;
            rve_pkg::CMD_EBREAK: o_res.halt = 1'b1;
            default: ;
        endcase
        if (taken) begin
            o_res.npc = i_pc + i_imm;
        end
    end
endmodule
`default_nettype wire

### src/rve_dmem.sv
// Byte data memory as four byte lanes; misaligned accesses split across lanes.
// Depends on rve_pkg and rve_ram. Clears all rows after reset.
`default_nettype none
module rve_dmem #(
    parameter int MEM_BYTES = rve_pkg::MEM_BYTES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  rve_pkg::t_mem_req      i_req,
    output logic                   o_busy,
    output logic [31:0]            o_rdata
);
    localparam int ROWS = MEM_BYTES / 4;
    localparam int RW   = $clog2(ROWS);

    logic          r_clr;
    logic [RW-1:0] r_clr_row;
    logic [1:0]    r_off;
    logic [2:0]    nbytes;
    logic [7:0]    lane_q [4];

    always_comb begin
        case (i_req.size)
            rve_pkg::SZ_B: nbytes = 3'd1;
            rve_pkg::SZ_H: nbytes = 3'd2;
            default:       nbytes = 3'd4;
        endcase
    end

    for (genvar l = 0; l < 4; l++) begin : g_lane
        logic [1:0]    k;
        logic [RW-1:0] row;
        logic          we;
        logic [7:0]    wd;
        logic [31:0]   sh;

        always_comb begin
            k   = 2'(l) - i_req.addr[1:0];
            row = i_req.addr[RW+1:2] + RW'(2'(l) < i_req.addr[1:0]);
            sh  = i_req.data >> {k, 3'b000};
            we  = i_req.wr && ({1'b0, k} < nbytes);
            wd  = sh[7:0];
            if (r_clr) begin
                we  = 1'b1;
                wd  = '0;
            end
        end

        rve_ram #(.WIDTH(8), .DEPTH(ROWS)) u_lane (
            .i_clk  (i_clk),
            .i_we   (we),
            .i_waddr(r_clr ? r_clr_row : row),
            .i_wdata(wd),
            .i_re   (i_req.rd),
            .i_raddr(row),
            .o_rdata(lane_q[l])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= 1'b1;
            r_clr_row <= '0;
        end else if (r_clr) begin
            r_clr_row <= r_clr_row + 1'b1;
            if (&r_clr_row) begin
                r_clr <= 1'b0;
            end
        end
        if (i_req.rd) begin
            r_off <= i_req.addr[1:0];
        end
    end

    always_comb begin
        for (int b = 0; b < 4; b++) begin
            o_rdata[8*b +: 8] = lane_q[2'(r_off + 2'(b))];
        end
    end

    assign o_busy = r_clr;
endmodule
`default_nettype wire
